// ===== rtl/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg : shared types and constants of the stride prefetcher with queue
// Default parameters, operation codes, register indexes, the bundle type of the
// control registers and the state type of the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
package spq_pkg;
   localparam int DefWays       = 8;
   localparam int DefSets       = 4;
   localparam int DefQueueDepth = 32;
   localparam int DefMaxDegree  = 8;

   localparam logic OP_TRAIN = 1'b0;
   localparam logic OP_POP   = 1'b1;

   localparam logic [2:0] REG_MAX_CONF     = 3'd0;
   localparam logic [2:0] REG_MIN_CONF     = 3'd1;
   localparam logic [2:0] REG_THRESH_CONF  = 3'd2;
   localparam logic [2:0] REG_START_CONF   = 3'd3;
   localparam logic [2:0] REG_DEGREE       = 3'd4;
   localparam logic [2:0] REG_QUEUE_FILTER = 3'd5;
   localparam logic [2:0] REG_BLOCK_BYTES  = 3'd6;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 13;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_GEN,
      ST_DONE
   } state_type;

   // control registers as one bundle
   typedef struct packed {
      logic [2:0]  max_conf;
      logic [2:0]  min_conf;
      logic [2:0]  thresh_conf;
      logic [2:0]  start_conf;
      logic [3:0]  degree;
      logic        queue_filter;
      logic [12:0] block_bytes;
   } csr_type;
endpackage
`default_nettype wire

// ===== rtl/spq_csr.sv =====
// ---------------------------------------------------------------------------
// spq_csr : control registers
// Write-only register bank, values masked to register width.
// ---------------------------------------------------------------------------
`default_nettype none
module spq_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write,
   input  wire [spq_pkg::CsrIndexWidth-1:0]      csr_index,
   input  wire [spq_pkg::CsrDataWidth-1:0]       csr_data,
   output spq_pkg::csr_type                      csr_out
);
   import spq_pkg::*;

   csr_type regs_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.max_conf     <= 3'd7;
         regs_ff.min_conf     <= 3'd0;
         regs_ff.thresh_conf  <= 3'd4;
         regs_ff.start_conf   <= 3'd4;
         regs_ff.degree       <= 4'd1;
         regs_ff.queue_filter <= 1'b1;
         regs_ff.block_bytes  <= 13'd128;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAX_CONF:     regs_ff.max_conf     <= csr_data[2:0];
            REG_MIN_CONF:     regs_ff.min_conf     <= csr_data[2:0];
            REG_THRESH_CONF:  regs_ff.thresh_conf  <= csr_data[2:0];
            REG_START_CONF:   regs_ff.start_conf   <= csr_data[2:0];
            REG_DEGREE:       regs_ff.degree       <= csr_data[3:0];
            REG_QUEUE_FILTER: regs_ff.queue_filter <= csr_data[0];
            REG_BLOCK_BYTES:  regs_ff.block_bytes  <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_out = regs_ff;
endmodule
`default_nettype wire

// ===== rtl/stride_prefetcher_with_queue.sv =====
// ---------------------------------------------------------------------------
// stride_prefetcher_with_queue : pc stride prefetcher with prefetch queue
// Table of SETS x WAYS entries in one memory (one row per set), queue in a
// second memory; a sequencer reads, trains and writes back.
// ---------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid/req_ready, operation, address, pc, warp
//  rsp     | out       | rsp_valid/rsp_ready, result fields
//  csr     | in        | csr_write, csr_index, csr_data
//
// Pop and train without prefetch pass ST_LOOKUP and ST_DONE; the response is
// raised once the head read has landed, then ST_IDLE takes the next request.
// Train hit that prefetches adds ST_GEN: per candidate, one compare per queued
// entry passed before a match (filter on), then the candidate is pushed or dropped.
// Reset clears the table valid row bits and the queue pointers.
// A waiting result holds the block; the next request enters after it is taken.
`default_nettype none
module stride_prefetcher_with_queue #(
   parameter int WAYS        = spq_pkg::DefWays,
   parameter int SETS        = spq_pkg::DefSets,
   parameter int QUEUE_DEPTH = spq_pkg::DefQueueDepth,
   parameter int MAX_DEGREE  = spq_pkg::DefMaxDegree
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_operation,
   input  wire  [31:0] req_access_addr,
   input  wire  [31:0] req_pc,
   input  wire  [5:0]  req_warp_id,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_table_hit,
   output logic [3:0]  rsp_queued_count,
   output logic [3:0]  rsp_duplicate_count,
   output logic [3:0]  rsp_evicted_count,
   output logic        rsp_head_valid,
   output logic [31:0] rsp_head_addr,
   output logic [5:0]  rsp_queue_count,
   output logic        rsp_pop_error,
   input  wire         csr_write,
   input  wire  [spq_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire  [spq_pkg::CsrDataWidth-1:0]  csr_data
);
   import spq_pkg::*;

   localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = 32 + 6 + 32 + 32 + 3;   // pc, warp, last, stride, conf

   typedef struct packed {
      logic [31:0] pc;
      logic [5:0]  warp;
      logic [31:0] last;
      logic [31:0] stride;
      logic [2:0]  conf;
   } entry_type;

   // queue slot at an offset from a pointer, wrapping at the depth
   function automatic logic [QW-1:0] q_wrap(input logic [QW-1:0] ptr,
                                            input logic [FW-1:0] offs);
      logic [FW:0] sum;
      sum = (FW+1)'(ptr) + (FW+1)'(offs);
      if (sum >= (FW+1)'(QUEUE_DEPTH)) sum = sum - (FW+1)'(QUEUE_DEPTH);
      return QW'(sum);
   endfunction

   csr_type csr;
   spq_csr u_csr (.clock, .reset, .csr_write, .csr_index, .csr_data, .csr_out(csr));

   // memories
   logic [WAYS*EW-1:0] table_mem [SETS];
   logic [31:0]        queue_mem [QUEUE_DEPTH];
   logic [WAYS-1:0]    valid_ff [SETS];
   logic [WAYS*EW-1:0] row_rd_ff;
   logic [31:0]        q_rd_ff;

   state_type state_ff, state_in;
   logic        op_ff;
   logic [31:0] addr_ff, pc_ff;
   logic [5:0]  warp_ff;
   logic [SW-1:0] set_ff;
   logic [QW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0]   head_addr_ff;
   logic [31:0]   ps_ff, cand_ff;
   logic [4:0]    deg_ff, d_ff;
   logic [FW-1:0] scan_ff;
   logic          dup_now;
   logic          hit_ff, perr_ff;
   logic [3:0]    queued_ff, dups_ff, evict_ff;

   // set index from a constant table of the warp
   logic [SW-1:0] req_set;
   always_comb begin
      req_set = '0;
      for (int v = 0; v < 64; v++) begin
         if (req_warp_id == 6'(v)) req_set = SW'(v % SETS);
      end
   end

   // read address of the queue memory
   logic [QW-1:0] q_rd_addr;
   logic [QW-1:0] q_wr_addr;
   logic          q_we;
   logic [31:0]   q_wd;
   logic          t_we;
   logic [WAYS*EW-1:0] t_wd;
   logic [WAYS-1:0]    v_wd;

   // queue read forwards a write to the same slot
   always_ff @(posedge clock) begin
      row_rd_ff <= table_mem[req_set];
      if (t_we) table_mem[set_ff] <= t_wd;
      if (q_we && q_wr_addr == q_rd_addr) q_rd_ff <= q_wd;
      else                                q_rd_ff <= queue_mem[q_rd_addr];
      if (q_we) queue_mem[q_wr_addr] <= q_wd;
   end

   // lookup on the read row
   entry_type e [WAYS];
   logic [WAYS-1:0] match;
   logic [WW-1:0]   hit_way, victim;
   logic            found, got_inv;
   logic [2:0]      best_conf;
   always_comb begin
      found = 1'b0; hit_way = '0; got_inv = 1'b0; victim = '0;
      for (int w = 0; w < WAYS; w++) begin
         e[w] = row_rd_ff[w*EW +: EW];
         match[w] = valid_ff[set_ff][w] && e[w].pc == pc_ff && e[w].warp == warp_ff;
      end
      for (int w = WAYS-1; w >= 0; w--) begin
         if (match[w]) begin found = 1'b1; hit_way = WW'(w); end
      end
      for (int w = WAYS-1; w >= 0; w--) begin
         if (!valid_ff[set_ff][w]) begin got_inv = 1'b1; victim = WW'(w); end
      end
      best_conf = e[0].conf;
      if (!got_inv) begin
         victim = '0;
         for (int w = 1; w < WAYS; w++) begin
            if (e[w].conf < best_conf) begin best_conf = e[w].conf; victim = WW'(w); end
         end
      end
   end

   // training of the hit entry
   entry_type hit_e, new_e;
   logic [31:0] ns, mag, ps;
   logic [2:0]  c;
   logic        neg;
   always_comb begin
      hit_e = e[hit_way];
      ns = addr_ff - hit_e.last;
      c  = hit_e.conf;
      new_e = hit_e;
      if (ns == hit_e.stride && ns != 32'd0) begin
         if (c < csr.max_conf) c = c + 3'd1;
      end else begin
         if (c > csr.min_conf) c = c - 3'd1;
         if (c < csr.thresh_conf) new_e.stride = ns;
      end
      new_e.conf = c;
      new_e.last = addr_ff;
      neg = ns[31];
      mag = neg ? (32'd0 - ns) : ns;
      ps  = ns;
      if (mag != 32'h8000_0000 && mag < {19'd0, csr.block_bytes})
         ps = neg ? (32'd0 - {19'd0, csr.block_bytes}) : {19'd0, csr.block_bytes};
   end

   logic [4:0] deg_lim;
   always_comb begin
      if ({1'b0, csr.degree} > 5'(MAX_DEGREE)) deg_lim = 5'(MAX_DEGREE);
      else                                   deg_lim = {1'b0, csr.degree};
   end

   // table write data
   entry_type fill_e;
   always_comb begin
      fill_e.pc = pc_ff; fill_e.warp = warp_ff; fill_e.last = addr_ff;
      fill_e.stride = '0; fill_e.conf = csr.start_conf;
      t_wd = row_rd_ff;
      v_wd = valid_ff[set_ff];
      if (found) t_wd[hit_way*EW +: EW] = new_e;
      else begin
         t_wd[victim*EW +: EW] = fill_e;
         v_wd[victim] = 1'b1;
      end
   end

   // response timing flags
   logic in_done_ff;
   logic rsp_ok;
   assign rsp_ok = (state_ff == ST_DONE) && !in_done_ff;

   // sequencer
   logic full;
   assign full = (fill_ff == FW'(QUEUE_DEPTH));
   logic [FW-1:0] scan_in;
   always_comb begin
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      t_we = 1'b0; q_we = 1'b0;
      head_in = head_ff; fill_in = fill_ff;
      q_wr_addr = q_wrap(head_ff, fill_ff);
      q_wd = cand_ff;
      scan_in = scan_ff;
      q_rd_addr = q_wrap(head_ff, scan_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (op_ff == OP_POP) begin
               if (fill_ff != '0) begin
                  head_in = q_wrap(head_ff, FW'(1));
                  fill_in = fill_ff - 1'b1;
               end
               q_rd_addr = head_in;
               state_in = ST_DONE;
            end else begin
               t_we = 1'b1;
               if (found && new_e.conf > csr.thresh_conf && deg_lim != '0)
                  state_in = ST_GEN;
               else begin
                  q_rd_addr = head_ff;
                  state_in = ST_DONE;
               end
               scan_in = '0;
               q_rd_addr = head_ff;
            end
         end
         ST_GEN: begin
            // scan one queued entry per cycle, then push or drop the candidate
            if (csr.queue_filter && scan_ff < fill_ff && !dup_now) begin
               scan_in = scan_ff + 1'b1;
               q_rd_addr = q_wrap(head_ff, scan_in);
            end else begin
               if (!(csr.queue_filter && dup_now)) begin
                  q_we = 1'b1;
                  if (full) begin
                     head_in = q_wrap(head_ff, FW'(1));
                     q_wr_addr = head_ff;
                  end else fill_in = fill_ff + 1'b1;
               end
               scan_in = '0;
               q_rd_addr = head_in;
               if (d_ff == deg_ff) state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ok && rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // dup flag compares the registered read against the candidate
   logic scan_live_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         for (int s = 0; s < SETS; s++) valid_ff[s] <= '0;
         scan_live_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         if (t_we) valid_ff[set_ff] <= v_wd;
         scan_live_ff <= (state_in == ST_GEN) && (scan_in < fill_in);
      end
   end

   assign dup_now = scan_live_ff && (q_rd_ff == cand_ff);

   // request capture and counters
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff <= req_operation; addr_ff <= req_access_addr;
         pc_ff <= req_pc; warp_ff <= req_warp_id; set_ff <= req_set;
         hit_ff <= 1'b0; queued_ff <= '0; dups_ff <= '0; evict_ff <= '0;
         perr_ff <= 1'b0;
      end
      if (state_ff == ST_LOOKUP) begin
         if (op_ff == OP_POP) perr_ff <= (fill_ff == '0);
         else hit_ff <= found;
         ps_ff <= ps; deg_ff <= deg_lim; d_ff <= 5'd1;
         cand_ff <= addr_ff + ps;
      end
      if (state_ff == ST_GEN && !(csr.queue_filter && scan_ff < fill_ff && !dup_now)) begin
         if (csr.queue_filter && dup_now) dups_ff <= dups_ff + 1'b1;
         else begin
            queued_ff <= queued_ff + 1'b1;
            if (full) evict_ff <= evict_ff + 1'b1;
         end
         d_ff <= d_ff + 1'b1;
         cand_ff <= cand_ff + ps_ff;
      end
      scan_ff <= scan_in;
   end

   // head address: queue read of the head lands on entering ST_DONE
   always_ff @(posedge clock) begin
      if (reset) in_done_ff <= 1'b0;
      else       in_done_ff <= (state_ff != ST_DONE) && (state_in == ST_DONE);
   end
   always_ff @(posedge clock) begin
      if (in_done_ff) head_addr_ff <= q_rd_ff;
   end

   assign rsp_valid           = rsp_ok;
   assign rsp_table_hit       = hit_ff;
   assign rsp_queued_count    = queued_ff;
   assign rsp_duplicate_count = dups_ff;
   assign rsp_evicted_count   = evict_ff;
   assign rsp_head_valid      = (fill_ff != '0);
   assign rsp_head_addr       = (fill_ff != '0) ? head_addr_ff : 32'd0;
   assign rsp_queue_count     = 6'(fill_ff);
   assign rsp_pop_error       = perr_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result waits");
   a_perr_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pop_error |-> rsp_queue_count == '0) else $error("pop error on fill");
endmodule
`default_nettype wire
